FILE: rtl/core/cge_pkg.sv
package cge_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int DW        = 32;              // coordinate and velocity width
  localparam int DT_W      = 17;              // time step width
  localparam int AXES      = 3;
  localparam int DM_W      = DW + 1;          // magnitude of a pivot offset
  localparam int D2_W      = 2 * DM_W;        // squared distance
  localparam int GM_W      = 2 * DW;          // grav_constant * central_mass
  localparam int ROOT_W    = DM_W;            // integer square root of d2
  localparam int MAG_W     = DW - 1;          // acceleration magnitude
  localparam int SUM_W     = 52;              // signed sums before saturation
  localparam int CFG_IDX_W = 3;

  localparam logic [DW-1:0] GRAV_RST = 32'd65536;
  localparam logic [DW-1:0] MASS_RST = 32'd655360000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAV = 3'd0,
    REG_MASS = 3'd1,
    REG_PIVX = 3'd2,
    REG_PIVY = 3'd3,
    REG_PIVZ = 3'd4
  } cfg_idx_t;

  // Per-item payload that rides alongside the arithmetic units.
  typedef struct packed {
    logic [AXES-1:0][DW-1:0]   pos;
    logic [AXES-1:0][DW-1:0]   vel;
    logic [DT_W-1:0]           dt;
    logic [AXES-1:0][DM_W-1:0] dmag;
    logic [AXES-1:0]           dneg;
    logic                      coin;
  } side_t;

endpackage

FILE: rtl/core/cge_root_mag.sv
module cge_root_mag #(
  parameter int FRAC_BITS = cge_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    en,
  input  logic                                    in_valid,
  input  logic [cge_pkg::D2_W-1:0]                d2,
  input  logic [cge_pkg::GM_W+FRAC_BITS-1:0]      num,
  input  cge_pkg::side_t                          side_in,
  output logic                                    out_valid,
  output logic [cge_pkg::ROOT_W-1:0]              distance,
  output logic [cge_pkg::MAG_W-1:0]               mag,
  output logic                                    mag_ovf,
  output cge_pkg::side_t                          side_out
);

  localparam int NUM_W = cge_pkg::GM_W + FRAC_BITS;
  localparam int NS    = cge_pkg::ROOT_W;       // one root bit per stage
  localparam int QB    = cge_pkg::MAG_W + 1;    // quotient bits, top bit means saturate
  localparam int RR_W  = cge_pkg::ROOT_W + 2;
  localparam int CW    = cge_pkg::D2_W + QB - 1;

  logic                        v_r    [NS];
  logic [RR_W-1:0]             rr_r   [NS];
  logic [cge_pkg::ROOT_W-1:0]  root_r [NS];
  logic [cge_pkg::D2_W-1:0]    rad_r  [NS];
  logic [NUM_W-1:0]            qrem_r [NS];
  logic [QB-1:0]               q_r    [NS];
  logic [cge_pkg::D2_W-1:0]    d2_r   [NS];
  cge_pkg::side_t              side_r [NS];

  logic                        p_v    [NS];
  logic [RR_W-1:0]             p_rr   [NS];
  logic [cge_pkg::ROOT_W-1:0]  p_root [NS];
  logic [cge_pkg::D2_W-1:0]    p_rad  [NS];
  logic [NUM_W-1:0]            p_qrem [NS];
  logic [QB-1:0]               p_q    [NS];
  logic [cge_pkg::D2_W-1:0]    p_d2   [NS];
  cge_pkg::side_t              p_side [NS];

  for (genvar k = 0; k < NS; k++) begin : g_st
    logic [RR_W+1:0]            tmp;
    logic [RR_W-1:0]            trial;
    logic [RR_W-1:0]            rr_nxt;
    logic [cge_pkg::ROOT_W-1:0] root_nxt;
    logic [NUM_W-1:0]           qrem_nxt;
    logic [QB-1:0]              q_nxt;

    if (k == 0) begin : g_first
      assign p_v[k]    = in_valid;
      assign p_rr[k]   = '0;
      assign p_root[k] = '0;
      assign p_rad[k]  = d2;
      assign p_qrem[k] = num;
      assign p_q[k]    = '0;
      assign p_d2[k]   = d2;
      assign p_side[k] = side_in;
    end else begin : g_next
      assign p_v[k]    = v_r[k-1];
      assign p_rr[k]   = rr_r[k-1];
      assign p_root[k] = root_r[k-1];
      assign p_rad[k]  = rad_r[k-1];
      assign p_qrem[k] = qrem_r[k-1];
      assign p_q[k]    = q_r[k-1];
      assign p_d2[k]   = d2_r[k-1];
      assign p_side[k] = side_r[k-1];
    end

    // Square root: bring down two radicand bits and try the next root bit.
    always_comb begin
      tmp   = {p_rr[k], p_rad[k][cge_pkg::D2_W-1 -: 2]};
      trial = {p_root[k][cge_pkg::ROOT_W-1:0], 2'b01};
      if (tmp >= (RR_W+2)'(trial)) begin
        rr_nxt   = RR_W'(tmp - (RR_W+2)'(trial));
        root_nxt = {p_root[k][cge_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rr_nxt   = RR_W'(tmp);
        root_nxt = {p_root[k][cge_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    // Magnitude: one restoring division step per stage, top bit first.
    if (k < QB) begin : g_div
      logic [CW-1:0] t;
      always_comb begin
        t        = CW'(p_d2[k]) << (QB - 1 - k);
        qrem_nxt = p_qrem[k];
        q_nxt    = p_q[k];
        if (t <= CW'(p_qrem[k])) begin
          qrem_nxt = NUM_W'(CW'(p_qrem[k]) - t);
          q_nxt[QB-1-k] = 1'b1;
        end
      end
    end else begin : g_pass
      assign qrem_nxt = p_qrem[k];
      assign q_nxt    = p_q[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= p_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rr_r[k]   <= rr_nxt;
        root_r[k] <= root_nxt;
        rad_r[k]  <= p_rad[k] << 2;
        qrem_r[k] <= qrem_nxt;
        q_r[k]    <= q_nxt;
        d2_r[k]   <= p_d2[k];
        side_r[k] <= p_side[k];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign distance  = root_r[NS-1];
  assign mag_ovf   = q_r[NS-1][QB-1] && (d2_r[NS-1] != '0);
  assign mag       = q_r[NS-1][QB-1] ? '1 : q_r[NS-1][cge_pkg::MAG_W-1:0];
  assign side_out  = side_r[NS-1];

endmodule

FILE: rtl/core/cge_acc_div.sv
module cge_acc_div (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               en,
  input  logic                                               in_valid,
  input  logic [cge_pkg::ROOT_W-1:0]                         distance,
  input  logic [cge_pkg::MAG_W-1:0]                          mag,
  input  logic                                               mag_ovf,
  input  cge_pkg::side_t                                     side_in,
  output logic                                               out_valid,
  output logic [cge_pkg::AXES-1:0][cge_pkg::MAG_W-1:0]       acc,
  output logic                                               ovf_out,
  output cge_pkg::side_t                                     side_out
);

  localparam int PW = cge_pkg::MAG_W + cge_pkg::DM_W;
  localparam int NS = cge_pkg::MAG_W;
  localparam int AX = cge_pkg::AXES;

  // Product stage ahead of the divider.
  logic                         m_v_r;
  logic [AX-1:0][PW-1:0]        m_prod_r;
  logic [cge_pkg::ROOT_W-1:0]   m_dist_r;
  logic                         m_ovf_r;
  cge_pkg::side_t               m_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < AX; l++) begin
        m_prod_r[l] <= PW'(mag) * PW'(side_in.dmag[l]);
      end
      m_dist_r <= distance;
      m_ovf_r  <= mag_ovf;
      m_side_r <= side_in;
    end
  end

  logic                         v_r    [NS];
  logic [AX-1:0][PW-1:0]        rem_r  [NS];
  logic [AX-1:0][NS-1:0]        q_r    [NS];
  logic [cge_pkg::ROOT_W-1:0]   dist_r [NS];
  logic                         ovf_r  [NS];
  cge_pkg::side_t               side_r [NS];

  logic                         p_v    [NS];
  logic [AX-1:0][PW-1:0]        p_rem  [NS];
  logic [AX-1:0][NS-1:0]        p_q    [NS];
  logic [cge_pkg::ROOT_W-1:0]   p_dist [NS];
  logic                         p_ovf  [NS];
  cge_pkg::side_t               p_side [NS];

  for (genvar k = 0; k < NS; k++) begin : g_st
    logic [PW-1:0]         t;
    logic [AX-1:0][PW-1:0] rem_nxt;
    logic [AX-1:0][NS-1:0] q_nxt;

    if (k == 0) begin : g_first
      assign p_v[k]    = m_v_r;
      assign p_rem[k]  = m_prod_r;
      assign p_q[k]    = '0;
      assign p_dist[k] = m_dist_r;
      assign p_ovf[k]  = m_ovf_r;
      assign p_side[k] = m_side_r;
    end else begin : g_next
      assign p_v[k]    = v_r[k-1];
      assign p_rem[k]  = rem_r[k-1];
      assign p_q[k]    = q_r[k-1];
      assign p_dist[k] = dist_r[k-1];
      assign p_ovf[k]  = ovf_r[k-1];
      assign p_side[k] = side_r[k-1];
    end

    // The quotient never exceeds mag, since no offset exceeds the rounded-down distance.
    always_comb begin
      t       = PW'(p_dist[k]) << (NS - 1 - k);
      rem_nxt = p_rem[k];
      q_nxt   = p_q[k];
      for (int l = 0; l < AX; l++) begin
        if (t <= p_rem[k][l]) begin
          rem_nxt[l] = p_rem[k][l] - t;
          q_nxt[l][NS-1-k] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= p_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        q_r[k]    <= q_nxt;
        dist_r[k] <= p_dist[k];
        ovf_r[k]  <= p_ovf[k];
        side_r[k] <= p_side[k];
      end
    end
  end

  // A body on the centre gets no acceleration; its divider result is meaningless.
  assign out_valid = v_r[NS-1];
  assign acc       = side_r[NS-1].coin ? '0 : q_r[NS-1];
  assign ovf_out   = ovf_r[NS-1];
  assign side_out  = side_r[NS-1];

endmodule

FILE: rtl/core/cge_integrate.sv
module cge_integrate #(
  parameter int FRAC_BITS = cge_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          en,
  input  logic                                          in_valid,
  input  logic [cge_pkg::AXES-1:0][cge_pkg::MAG_W-1:0]  acc,
  input  logic                                          ovf_in,
  input  cge_pkg::side_t                                side_in,
  output logic                                          out_valid,
  output logic [cge_pkg::AXES-1:0][cge_pkg::DW-1:0]     new_pos,
  output logic [cge_pkg::AXES-1:0][cge_pkg::DW-1:0]     new_vel,
  output logic                                          coincident,
  output logic                                          overflowed
);

  localparam int AX = cge_pkg::AXES;
  localparam int DW = cge_pkg::DW;
  localparam int SW = cge_pkg::SUM_W;
  localparam int P1 = cge_pkg::MAG_W + cge_pkg::DT_W;
  localparam int P2 = DW + cge_pkg::DT_W;

  // Clamp to 32 bits; the top bit of the result reports a clamp.
  function automatic logic [DW:0] sat32(input logic signed [SW-1:0] x);
    logic [SW-DW:0] hi;
    hi = x[SW-1:DW-1];
    if (hi != '0 && hi != '1) begin
      sat32 = x[SW-1] ? {1'b1, 1'b1, {(DW-1){1'b0}}} : {1'b1, 1'b0, {(DW-1){1'b1}}};
    end else begin
      sat32 = {1'b0, x[DW-1:0]};
    end
  endfunction

  // Velocity stage.
  logic                      v1_r;
  logic [AX-1:0][DW-1:0]     nv_r;
  logic [AX-1:0][DW-1:0]     pos1_r;
  logic [cge_pkg::DT_W-1:0]  dt1_r;
  logic                      coin1_r;
  logic                      ovf1_r;

  logic [AX-1:0][DW-1:0]     nv_nxt;
  logic                      ovf1_nxt;

  always_comb begin
    logic [P1-1:0]         prod;
    logic signed [SW-1:0]  sc;
    logic signed [SW-1:0]  sum;
    logic [DW:0]           s;
    ovf1_nxt = ovf_in;
    for (int l = 0; l < AX; l++) begin
      prod = P1'(acc[l]) * P1'(side_in.dt);
      sc   = SW'(prod >> FRAC_BITS);
      sum  = SW'($signed(side_in.vel[l])) + (side_in.dneg[l] ? -sc : sc);
      s    = sat32(sum);
      nv_nxt[l] = s[DW-1:0];
      ovf1_nxt  = ovf1_nxt | s[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nv_r    <= nv_nxt;
      pos1_r  <= side_in.pos;
      dt1_r   <= side_in.dt;
      coin1_r <= side_in.coin;
      ovf1_r  <= ovf1_nxt;
    end
  end

  // Position stage, using the new velocity; this is the output register.
  logic                      v2_r;
  logic [AX-1:0][DW-1:0]     np_r;
  logic [AX-1:0][DW-1:0]     nv2_r;
  logic                      coin2_r;
  logic                      ovf2_r;

  logic [AX-1:0][DW-1:0]     np_nxt;
  logic                      ovf2_nxt;

  always_comb begin
    logic [DW-1:0]         nvm;
    logic [P2-1:0]         prod;
    logic signed [SW-1:0]  sc;
    logic signed [SW-1:0]  sum;
    logic [DW:0]           s;
    ovf2_nxt = ovf1_r;
    for (int l = 0; l < AX; l++) begin
      nvm  = nv_r[l][DW-1] ? DW'(-nv_r[l]) : nv_r[l];
      prod = P2'(nvm) * P2'(dt1_r);
      sc   = SW'(prod >> FRAC_BITS);
      sum  = SW'($signed(pos1_r[l])) + (nv_r[l][DW-1] ? -sc : sc);
      s    = sat32(sum);
      np_nxt[l] = s[DW-1:0];
      ovf2_nxt  = ovf2_nxt | s[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      np_r    <= np_nxt;
      nv2_r   <= nv_r;
      coin2_r <= coin1_r;
      ovf2_r  <= ovf2_nxt;
    end
  end

  assign out_valid  = v2_r;
  assign new_pos    = np_r;
  assign new_vel    = nv2_r;
  assign coincident = coin2_r;
  assign overflowed = ovf2_r;

endmodule

FILE: rtl/core/central_gravity_euler_step_core.sv
// Channel  Direction  Payload (lowest bits first)
// in_      in         tdata: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, time_step, zero pad
// out_     out        tdata: new_pos_x/y/z, new_vel_x/y/z; tuser: coincident, overflowed
// cfg_     in         write enable, register index, 32-bit data
//
// One item enters per cycle while no result waits on out_tready, and passes 70 register
// stages: three offset/square/sum stages, 33 square-root stages (one root bit each, running
// beside the magnitude division), a product stage and 31 per-axis division stages, and two
// integration stages.
// Reset is synchronous; it clears the valid bits and loads the configuration reset values.
// The whole pipeline holds while a result waits on out_tready; nothing is lost or repeated.
module central_gravity_euler_step_core #(
  parameter int FRAC_BITS = cge_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cge_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cge_pkg::DW-1:0]            cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, time_step, 7 zero bits
  input  logic [215:0]                      in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
  output logic [6*cge_pkg::DW-1:0]          out_tdata,
  // coincident, overflowed
  output logic [1:0]                        out_tuser
);

  localparam int AX    = cge_pkg::AXES;
  localparam int DW    = cge_pkg::DW;
  localparam int DM_W  = cge_pkg::DM_W;
  localparam int D2_W  = cge_pkg::D2_W;
  localparam int NUM_W = cge_pkg::GM_W + FRAC_BITS;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Configuration registers.
  logic [DW-1:0]         grav_r;
  logic [DW-1:0]         mass_r;
  logic [AX-1:0][DW-1:0] piv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= cge_pkg::GRAV_RST;
      mass_r <= cge_pkg::MASS_RST;
      piv_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cge_pkg::REG_GRAV: grav_r   <= cfg_wdata;
        cge_pkg::REG_MASS: mass_r   <= cfg_wdata;
        cge_pkg::REG_PIVX: piv_r[0] <= cfg_wdata;
        cge_pkg::REG_PIVY: piv_r[1] <= cfg_wdata;
        cge_pkg::REG_PIVZ: piv_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage A: offsets from the body to the centre.
  logic                   a_v_r;
  cge_pkg::side_t         a_side_r;
  logic [cge_pkg::GM_W-1:0] a_gm_r;
  cge_pkg::side_t         a_side_nxt;

  always_comb begin
    logic [DM_W-1:0] d;
    a_side_nxt.pos  = in_tdata[AX*DW-1:0];
    a_side_nxt.vel  = in_tdata[2*AX*DW-1:AX*DW];
    a_side_nxt.dt   = in_tdata[2*AX*DW +: cge_pkg::DT_W];
    a_side_nxt.coin = 1'b0;
    for (int i = 0; i < AX; i++) begin
      d = {piv_r[i][DW-1], piv_r[i]} - {a_side_nxt.pos[i][DW-1], a_side_nxt.pos[i]};
      a_side_nxt.dneg[i] = d[DM_W-1];
      a_side_nxt.dmag[i] = d[DM_W-1] ? DM_W'(-d) : d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r <= a_side_nxt;
      a_gm_r   <= cge_pkg::GM_W'(grav_r) * cge_pkg::GM_W'(mass_r);
    end
  end

  // Stage B: squares of the offsets.
  logic                     b_v_r;
  cge_pkg::side_t           b_side_r;
  logic [cge_pkg::GM_W-1:0] b_gm_r;
  logic [AX-1:0][D2_W-1:0]  b_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side_r <= a_side_r;
      b_gm_r   <= a_gm_r;
      for (int i = 0; i < AX; i++) begin
        b_sq_r[i] <= D2_W'(a_side_r.dmag[i]) * D2_W'(a_side_r.dmag[i]);
      end
    end
  end

  // Stage C: squared distance and the scaled numerator G*M.
  logic             c_v_r;
  cge_pkg::side_t   c_side_r;
  logic [D2_W-1:0]  c_d2_r;
  logic [NUM_W-1:0] c_num_r;
  logic [D2_W-1:0]  d2_nxt;
  cge_pkg::side_t   c_side_nxt;

  assign d2_nxt = b_sq_r[0] + b_sq_r[1] + b_sq_r[2];

  always_comb begin
    c_side_nxt      = b_side_r;
    c_side_nxt.coin = (d2_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side_r <= c_side_nxt;
      c_d2_r   <= d2_nxt;
      c_num_r  <= NUM_W'(b_gm_r) << FRAC_BITS;
    end
  end

  // Distance and acceleration magnitude.
  logic                        r_v;
  logic [cge_pkg::ROOT_W-1:0]  r_dist;
  logic [cge_pkg::MAG_W-1:0]   r_mag;
  logic                        r_ovf;
  cge_pkg::side_t              r_side;

  cge_root_mag #(.FRAC_BITS(FRAC_BITS)) u_root_mag (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_v_r),
    .d2        (c_d2_r),
    .num       (c_num_r),
    .side_in   (c_side_r),
    .out_valid (r_v),
    .distance  (r_dist),
    .mag       (r_mag),
    .mag_ovf   (r_ovf),
    .side_out  (r_side)
  );

  // Per-axis acceleration.
  logic                                    q_v;
  logic [AX-1:0][cge_pkg::MAG_W-1:0]       q_acc;
  logic                                    q_ovf;
  cge_pkg::side_t                          q_side;

  cge_acc_div u_acc_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (r_v),
    .distance  (r_dist),
    .mag       (r_mag),
    .mag_ovf   (r_ovf),
    .side_in   (r_side),
    .out_valid (q_v),
    .acc       (q_acc),
    .ovf_out   (q_ovf),
    .side_out  (q_side)
  );

  // Velocity, then position.
  logic [AX-1:0][DW-1:0] new_pos;
  logic [AX-1:0][DW-1:0] new_vel;
  logic                  coincident;
  logic                  overflowed;

  cge_integrate #(.FRAC_BITS(FRAC_BITS)) u_integrate (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (q_v),
    .acc        (q_acc),
    .ovf_in     (q_ovf),
    .side_in    (q_side),
    .out_valid  (out_tvalid),
    .new_pos    (new_pos),
    .new_vel    (new_vel),
    .coincident (coincident),
    .overflowed (overflowed)
  );

  assign out_tdata = {new_vel, new_pos};
  assign out_tuser = {overflowed, coincident};

endmodule

FILE: rtl/core/cge_checker.sv
module cge_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [6*cge_pkg::DW-1:0]  out_tdata,
  input logic [1:0]                out_tuser
);

  // The pipeline only refuses input while a finished result is held back.
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input refused without an output stall");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("stalled result withdrawn");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind central_gravity_euler_step_core cge_checker u_cge_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
